[rtl/pamm_pkg.sv]
// ----------------------------------------------------------------------------
// pamm_pkg
// Shared types and constants for the peripheral access map marker.
// ----------------------------------------------------------------------------
package pamm_pkg;

    localparam int unsigned BOX_COUNT_DEF = 8;
    localparam int unsigned ID_COUNT      = 256;
    localparam int unsigned ID_W          = 8;
    localparam int unsigned WORD_BITS     = 32;
    localparam int unsigned WORDS_PER_MAP = ID_COUNT / WORD_BITS;
    localparam int unsigned WORD_SEL_W    = $clog2(WORDS_PER_MAP);
    localparam int unsigned BIT_SEL_W     = $clog2(WORD_BITS);
    localparam int unsigned CNT_W         = 9;

    localparam logic [31:0] GRANULE_BYTES = 32'h0000_0400;

    localparam logic [7:0] TOP_APB    = 8'h40;
    localparam logic [7:0] TOP_FSMC   = 8'hA0;
    localparam logic [7:0] TOP_AHB2   = 8'h50;
    localparam logic [7:0] ID_USB_HS  = 8'hC0;
    localparam logic [7:0] ID_FSMC    = 8'hC1;
    localparam logic [7:0] ID_USB_FS  = 8'hC2;
    localparam logic [7:0] ID_DCMI    = 8'hC3;
    localparam logic [7:0] ID_CRYPTO  = 8'hC4;
    localparam logic [15:0] FSMC_LAST = 16'h0FFF;
    localparam logic [15:0] DCMI_LAST = 16'h03FF;
    localparam logic [15:0] CRYP_LAST = 16'h0BFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic            rd;
        logic            wr;
        logic [2:0]      box;
        logic [ID_W-1:0] id;
    } t_map_req;

endpackage

[rtl/pamm_if.sv]
// ----------------------------------------------------------------------------
// pamm_req_if / pamm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface pamm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  box_number;
    logic [31:0] start_address;
    logic [31:0] region_length;

    modport source (output valid, box_number, start_address, region_length, input ready);
    modport sink   (input valid, box_number, start_address, region_length, output ready);
endinterface

interface pamm_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [8:0]  newly_marked;
    logic [31:0] fault_address;

    modport source (output valid, status, newly_marked, fault_address, input ready);
    modport sink   (input valid, status, newly_marked, fault_address, output ready);
endinterface

[rtl/pamm_decode.sv]
// ----------------------------------------------------------------------------
// pamm_decode
// Bus map decoder: granule address to peripheral ID.
// ----------------------------------------------------------------------------
module pamm_decode (
    input  logic [31:0]              i_addr,
    output logic                     o_hit,
    output logic [pamm_pkg::ID_W-1:0] o_id
);
    import pamm_pkg::*;

    logic [7:0]  top;
    logic [7:0]  blk;
    logic [15:0] low;

    assign top = i_addr[31:24];
    assign blk = i_addr[23:16];
    assign low = i_addr[15:0];

    always_comb begin
        o_hit = 1'b0;
        o_id  = '0;
        if (top == TOP_APB) begin
            if (blk <= 8'h02) begin
                o_hit = 1'b1;
                o_id  = i_addr[17:10];
            end else if (blk > 8'h04 && blk <= 8'h07) begin
                o_hit = 1'b1;
                o_id  = ID_USB_HS;
            end
        end else if (top == TOP_FSMC) begin
            if (blk == 8'h00 && low <= FSMC_LAST) begin
                o_hit = 1'b1;
                o_id  = ID_FSMC;
            end
        end else if (top == TOP_AHB2) begin
            if (blk <= 8'h03) begin
                o_hit = 1'b1;
                o_id  = ID_USB_FS;
            end else if (blk == 8'h05 && low <= DCMI_LAST) begin
                o_hit = 1'b1;
                o_id  = ID_DCMI;
            end else if (blk == 8'h06 && low <= CRYP_LAST) begin
                o_hit = 1'b1;
                o_id  = ID_CRYPTO + {6'd0, low[11:10]};
            end
        end
    end

endmodule

[rtl/pamm_step.sv]
// ----------------------------------------------------------------------------
// pamm_step
// Shared walk unit: advances address and remaining length by one granule.
// ----------------------------------------------------------------------------
module pamm_step (
    input  logic [31:0] i_addr,
    input  logic [31:0] i_len,
    output logic [31:0] o_addr,
    output logic [31:0] o_len,
    output logic        o_last
);
    import pamm_pkg::*;

    assign o_last = (i_len <= GRANULE_BYTES);
    assign o_addr = i_addr + GRANULE_BYTES;
    assign o_len  = i_len - GRANULE_BYTES;

endmodule

[rtl/pamm_box_map.sv]
// ----------------------------------------------------------------------------
// pamm_box_map
// Per-box claim bitmaps in one memory, read-modify-write, cleared after reset.
// ----------------------------------------------------------------------------
module pamm_box_map #(
    parameter int unsigned BOX_COUNT = pamm_pkg::BOX_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pamm_pkg::t_map_req i_req,
    output logic               o_busy
);
    import pamm_pkg::*;

    localparam int unsigned DEPTH = BOX_COUNT * WORDS_PER_MAP;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_clr;
    logic                 r_busy;
    logic [AW-1:0]        addr;
    logic [WORD_BITS-1:0] bit_mask;

    assign addr     = AW'((32'(i_req.box) << WORD_SEL_W) | 32'(i_req.id[ID_W-1:BIT_SEL_W]));
    assign bit_mask = WORD_BITS'(1) << i_req.id[BIT_SEL_W-1:0];
    assign o_busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + AW'(1);
            if (r_clr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= '0;
        end else if (i_req.wr) begin
            r_mem[addr] <= r_rdata | bit_mask;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[addr];
        end
    end

endmodule

[rtl/peripheral_access_map_marker.sv]
// ----------------------------------------------------------------------------
// peripheral_access_map_marker
// Walks a region in 1 KiB granules and claims the decoded peripheral IDs.
//
//   channel  | dir | transfer payload
//   i_req    | in  | box_number, start_address, region_length
//   o_rsp    | out | status, newly_marked, fault_address
//
// One request walks at most ceil(len/1 KiB) granules, or one for a zero
// length; none if the box number is out of range, and the walk stops at the
// first granule that misses the bus map. The walk loop checks one granule a
// cycle, and a granule that claims a new ID adds a box map read-modify-write.
// After reset the box map is cleared, one word a cycle, BOX_COUNT * 8 words;
// no request is taken meanwhile. The result is held until taken.
// ----------------------------------------------------------------------------
module peripheral_access_map_marker #(
    parameter int unsigned BOX_COUNT = pamm_pkg::BOX_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pamm_req_if.sink    i_req,
    pamm_rsp_if.source  o_rsp
);
    import pamm_pkg::*;

    t_state               r_state, n_state;
    logic [2:0]           r_box;
    logic [31:0]          r_addr, n_addr;
    logic [31:0]          r_len, n_len;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_status, n_status;
    logic [31:0]          r_fault, n_fault;
    logic [ID_COUNT-1:0]  r_common, n_common;
    logic [ID_W-1:0]      r_id, n_id;

    logic                 dec_hit;
    logic [ID_W-1:0]      dec_id;
    logic [31:0]          step_addr, step_len;
    logic                 step_last;
    logic                 map_busy;
    logic                 box_ok;
    t_map_req             map_req;

    pamm_decode u_decode (
        .i_addr (r_addr),
        .o_hit  (dec_hit),
        .o_id   (dec_id)
    );

    pamm_step u_step (
        .i_addr (r_addr),
        .i_len  (r_len),
        .o_addr (step_addr),
        .o_len  (step_len),
        .o_last (step_last)
    );

    pamm_box_map #(
        .BOX_COUNT (BOX_COUNT)
    ) u_box_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_busy  (map_busy)
    );

    assign box_ok = ({4'd0, i_req.box_number} < 7'(BOX_COUNT));

    assign i_req.ready         = (r_state == S_IDLE) && !map_busy;
    assign o_rsp.valid         = (r_state == S_DONE);
    assign o_rsp.status        = r_status;
    assign o_rsp.newly_marked  = r_count;
    assign o_rsp.fault_address = r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_common <= '0;
        end else begin
            r_state  <= n_state;
            r_common <= n_common;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_box <= i_req.box_number;
        end
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_count  <= n_count;
        r_status <= n_status;
        r_fault  <= n_fault;
        r_id     <= n_id;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_len       = r_len;
        n_count     = r_count;
        n_status    = r_status;
        n_fault     = r_fault;
        n_common    = r_common;
        n_id        = r_id;
        map_req.rd  = 1'b0;
        map_req.wr  = 1'b0;
        map_req.box = r_box;
        map_req.id  = r_id;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_addr   = i_req.start_address;
                    n_len    = i_req.region_length;
                    n_count  = '0;
                    n_status = 1'b0;
                    n_fault  = '0;
                    n_state  = box_ok ? S_CHECK : S_DONE;
                end
            end
            S_CHECK: begin
                if (!dec_hit) begin
                    n_status = 1'b1;
                    n_fault  = r_addr;
                    n_state  = S_DONE;
                end else if (!r_common[dec_id]) begin
                    n_common[dec_id] = 1'b1;
                    n_count          = r_count + CNT_W'(1);
                    n_id             = dec_id;
                    map_req.rd       = 1'b1;
                    map_req.id       = dec_id;
                    n_state          = S_WRITE;
                end else if (step_last) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = step_addr;
                    n_len  = step_len;
                end
            end
            S_WRITE: begin
                map_req.wr = 1'b1;
                if (step_last) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = step_addr;
                    n_len   = step_len;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_write_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_CHECK))
        else $error("box map write without a preceding claim");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.newly_marked <= CNT_W'(ID_COUNT)))
        else $error("claim count beyond ID space");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.status) |-> (o_rsp.fault_address == 32'd0))
        else $error("fault address set on a completed walk");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_busy |-> !i_req.ready)
        else $error("request taken during box map clear");
`endif

endmodule

[tb/tb_peripheral_access_map_marker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_peripheral_access_map_marker
// Self-checking bench for the peripheral access map marker. Region requests
// go in from a backlog queue; an in-bench bus map decoder and claim bitmaps
// predict each result, and every result transfer is checked against the
// oldest prediction. Directed cases come first, then random regions aimed at
// each bus map window, its edges, the holes and the top of the address space.
// ----------------------------------------------------------------------------
module tb_peripheral_access_map_marker;
    import pamm_pkg::*;

    localparam int unsigned BOX_COUNT    = BOX_COUNT_DEF;
    localparam int          RANDOM_ITEMS = 1330;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          DRAIN_CYCLES = 600;
    localparam int          STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [2:0]  box;
        logic [31:0] addr;
        logic [31:0] len;
    } t_region_req;

    typedef struct packed {
        logic        status;
        logic [8:0]  marked;
        logic [31:0] fault;
    } t_region_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pamm_req_if req_ch ();
    pamm_rsp_if rsp_ch ();

    peripheral_access_map_marker #(
        .BOX_COUNT(BOX_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_region_req request_backlog[$];
    t_region_rsp awaited_results[$];
    logic [ID_COUNT-1:0] claimed_ids;
    logic [ID_COUNT-1:0] box_ids [BOX_COUNT];
    int fail_count = 0;
    int send_gap = 0;
    int sink_stall = 0;
    int quiet_cycles = 0;

    // Bus map decode of one granule address.
    function automatic bit decode_periph(input logic [31:0] a, output logic [7:0] pid);
        logic [7:0]  top;
        logic [7:0]  blk;
        logic [15:0] low;
        bit          hit;
        top = a[31:24];
        blk = a[23:16];
        low = a[15:0];
        pid = '0;
        hit = 1'b0;
        if (top == TOP_APB) begin
            if (blk <= 8'h02) begin
                pid = a[17:10];
                hit = 1'b1;
            end else if (blk > 8'h04 && blk <= 8'h07) begin
                pid = ID_USB_HS;
                hit = 1'b1;
            end
        end else if (top == TOP_FSMC) begin
            if (blk == 8'h00 && low <= FSMC_LAST) begin
                pid = ID_FSMC;
                hit = 1'b1;
            end
        end else if (top == TOP_AHB2) begin
            if (blk <= 8'h03) begin
                pid = ID_USB_FS;
                hit = 1'b1;
            end else if (blk == 8'h05 && low <= DCMI_LAST) begin
                pid = ID_DCMI;
                hit = 1'b1;
            end else if (blk == 8'h06 && low <= CRYP_LAST) begin
                pid = ID_CRYPTO + 8'(low >> 10);
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Walks one region, updates the claim maps and returns the result.
    function automatic t_region_rsp claim_region(input t_region_req rq);
        t_region_rsp r;
        logic [31:0] a;
        logic [31:0] left;
        logic [7:0]  pid;
        bit          walk_done;
        r = '0;
        a = rq.addr;
        left = rq.len;
        walk_done = (rq.box >= BOX_COUNT);
        while (!walk_done) begin
            if (!decode_periph(a, pid)) begin
                r.status = 1'b1;
                r.fault = a;
                walk_done = 1'b1;
            end else begin
                if (!claimed_ids[pid]) begin
                    claimed_ids[pid] = 1'b1;
                    box_ids[rq.box][pid] = 1'b1;
                    r.marked = r.marked + 9'd1;
                end
                if (left <= GRANULE_BYTES) begin
                    walk_done = 1'b1;
                end else begin
                    a = a + GRANULE_BYTES;
                    left = left - GRANULE_BYTES;
                end
            end
        end
        return r;
    endfunction

    function automatic t_region_req random_region();
        t_region_req rq;
        logic [31:0] edges [6];
        edges = '{32'h4002_FC00, 32'h4007_FC00, 32'hA000_0C00,
                  32'h5003_FC00, 32'h5004_FC00, 32'h5006_0800};
        rq.box = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 12))
            0, 1, 2, 3: rq.addr = 32'h4000_0000 + $urandom_range(0, 32'h2_FFFF);
            4:  rq.addr = 32'h4005_0000 + $urandom_range(0, 32'h2_FFFF);
            5:  rq.addr = 32'hA000_0000 + $urandom_range(0, 32'hFFF);
            6:  rq.addr = 32'h5000_0000 + $urandom_range(0, 32'h3_FFFF);
            7:  rq.addr = 32'h5005_0000 + $urandom_range(0, 32'h3FF);
            8:  rq.addr = 32'h5006_0000 + $urandom_range(0, 32'hBFF);
            9:  rq.addr = edges[$urandom_range(0, 5)] + $urandom_range(0, 32'h3FF);
            10: rq.addr = 32'h4003_0000 + $urandom_range(0, 32'h1_FFFF);
            11: rq.addr = $urandom;
            default: rq.addr = 32'hFFFF_F000 + $urandom_range(0, 32'hFFF);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: rq.len = $urandom_range(0, 4096);
            6: rq.len = GRANULE_BYTES * $urandom_range(0, 6) + $urandom_range(0, 1);
            7: rq.len = $urandom_range(0, 32'h4_0000);
            8: rq.len = $urandom;
            default: rq.len = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFFF);
        endcase
        return rq;
    endfunction

    task automatic add_region(input logic [2:0] box, input logic [31:0] addr,
                              input logic [31:0] len);
        request_backlog.push_back('{box: box, addr: addr, len: len});
    endtask

    // Request driver
    always @(posedge i_clk) begin : req_driver
        t_region_req rq;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (request_backlog.size() > QUIET_ITEMS && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 17) - 1;
                req_ch.valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
                rq = request_backlog.pop_front();
                req_ch.box_number <= rq.box;
                req_ch.start_address <= rq.addr;
                req_ch.region_length <= rq.len;
                req_ch.valid <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            rsp_ch.ready <= 1'b0;
        end else if (request_backlog.size() > QUIET_ITEMS && $urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(1, 17) - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Result check, then prediction of newly accepted requests
    always @(posedge i_clk) begin : result_check
        t_region_rsp want;
        t_region_req rq;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.newly_marked !== want.marked) begin
                        $error("newly_marked: expected %0d, actual %0d",
                               want.marked, rsp_ch.newly_marked);
                        fail_count++;
                    end
                    if (rsp_ch.fault_address !== want.fault) begin
                        $error("fault_address: expected %h, actual %h",
                               want.fault, rsp_ch.fault_address);
                        fail_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                rq.box = req_ch.box_number;
                rq.addr = req_ch.start_address;
                rq.len = req_ch.region_length;
                awaited_results.push_back(claim_region(rq));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.box_number = '0;
        req_ch.start_address = '0;
        req_ch.region_length = '0;
        rsp_ch.ready = 1'b0;
        claimed_ids = '0;
        for (int b = 0; b < BOX_COUNT; b++) begin
            box_ids[b] = '0;
        end

        // zero length, exact granule, one byte over, repeat of a claimed ID
        add_region(3'd0, 32'h4000_0000, 32'h0000_0000);
        add_region(3'd7, 32'h4000_0400, 32'h0000_0400);
        add_region(3'd1, 32'h4000_0800, 32'h0000_0401);
        add_region(3'd2, 32'h4000_0000, 32'h0000_0C00);
        // last APB granule, then fault in the hole behind it
        add_region(3'd3, 32'h4002_FC00, 32'h0000_0800);
        add_region(3'd4, 32'h4003_0000, 32'h0000_0000);
        // longest length stops at the hole after a few marks
        add_region(3'd5, 32'h4002_F000, 32'hFFFF_FFFF);
        // high speed USB, whole window, then past it
        add_region(3'd6, 32'h4005_0000, 32'h0003_0000);
        add_region(3'd6, 32'h4007_FC00, 32'h0000_0401);
        // static memory controller and its end
        add_region(3'd0, 32'hA000_0000, 32'h0000_1000);
        add_region(3'd1, 32'hA000_0FFF, 32'h0000_0401);
        // full speed USB
        add_region(3'd2, 32'h5000_0000, 32'h0004_0000);
        // camera interface, single granule and just past
        add_region(3'd3, 32'h5005_0000, 32'h0000_0000);
        add_region(3'd4, 32'h5005_0400, 32'h0000_0001);
        // crypto block, all three IDs then the first address past it
        add_region(3'd5, 32'h5006_0000, 32'h0000_0C00);
        add_region(3'd7, 32'h5006_0000, 32'h0000_0C01);
        // top of the address space and fully set fields
        add_region(3'd7, 32'hFFFF_FC00, 32'h0000_0800);
        add_region(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_region(3'd0, 32'h0000_0000, 32'h0000_0000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            request_backlog.push_back(random_region());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || req_ch.valid) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
